// File: design/mcft_pkg.sv
`default_nettype none

package mcft_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_ID    = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [7:0] CMD_READ  = 8'h52;
	localparam logic [7:0] CMD_WRITE = 8'h57;
	localparam logic [7:0] CMD_ID    = 8'h53;

	localparam int unsigned ID_LEN = 5;

	localparam logic [7:0] BYTE_FILL   = 8'hFF;
	localparam logic [7:0] FMT_MAGIC0  = 8'h4D;
	localparam logic [7:0] FMT_MAGIC1  = 8'h43;
	localparam logic [7:0] FMT_DIR_TAG = 8'hA0;

	localparam logic [7:0] ID_BYTE0 = 8'h5A;
	localparam logic [7:0] ID_BYTE1 = 8'h5A;
	localparam logic [7:0] ID_BYTE2 = 8'h00;
	localparam logic [7:0] ID_BYTE3 = 8'h00;
	localparam logic [7:0] ID_BYTE4 = 8'h80;

	function automatic logic [7:0] id_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = ID_BYTE0;
			3'd1: b = ID_BYTE1;
			3'd2: b = ID_BYTE2;
			3'd3: b = ID_BYTE3;
			3'd4: b = ID_BYTE4;
			default: b = BYTE_FILL;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: design/mcft_ram.sv
`default_nettype none

module mcft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/memory_card_frame_transfer_unit.sv
`default_nettype none

// channel   handshake              payload
// in        in_valid / in_stall    kind, command, sector, write_data
// out       out_valid / out_stall  read_data, idle
//
// one request per cycle while results are taken; a request passes through the
// card ram read stage (registered read), then sits in the output register
// after reset a formatting pass writes the card image,
// with in_stall held high
// out_stall holds the output register; the read stage behind it then holds
// and in_stall rises

module memory_card_frame_transfer_unit
	import mcft_pkg::*;
#(
	parameter int FRAME_BYTES = 128,
	parameter int CARD_BYTES  = 131072
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] command,
	input  wire logic [7:0] sector,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data,
	output logic            idle
);

	localparam int ADDR_W = $clog2(CARD_BYTES);
	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
	localparam int RED_W  = ADDR_W + 3;

	// check byte of the first frame: xor of the two magic bytes and, for an odd fill count, the fill
	localparam logic [7:0] FMT_CHECK = FMT_MAGIC0 ^ FMT_MAGIC1 ^
		(((FRAME_BYTES - 3) % 2 == 1) ? BYTE_FILL : 8'h00);

	localparam logic [RED_W-1:0] CARD_X1 = RED_W'(CARD_BYTES);
	localparam logic [RED_W-1:0] CARD_X2 = RED_W'(CARD_BYTES * 2);
	localparam logic [RED_W-1:0] CARD_X4 = RED_W'(CARD_BYTES * 4);

	mode_t             mode_q, mode_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [CNT_W-1:0]  count_q, count_d;

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [7:0]        clr_data;

	logic              valid_s1;
	logic              from_mem_s1;
	logic [7:0]        const_s1;
	logic              idle_s1;
	logic              from_mem_d;
	logic [7:0]        const_d;

	logic              s1_adv;
	logic              accept;

	logic [RED_W-1:0]  prod, red2, red1, red0;
	logic [ADDR_W:0]   addr_sum, addr_sum_red;
	logic [ADDR_W-1:0] item_addr;

	logic              item_we;
	logic              item_re;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	assign s1_adv   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;

	// frame base = sector * FRAME_BYTES mod CARD_BYTES, quotient below eight
	always_comb begin
		prod = RED_W'(sector) * RED_W'(FRAME_BYTES);
		red2 = (prod >= CARD_X4) ? prod - CARD_X4 : prod;
		red1 = (red2 >= CARD_X2) ? red2 - CARD_X2 : red2;
		red0 = (red1 >= CARD_X1) ? red1 - CARD_X1 : red1;
	end

	always_comb begin
		addr_sum     = {1'b0, base_q} + (ADDR_W+1)'(count_q);
		addr_sum_red = (addr_sum >= (ADDR_W+1)'(CARD_BYTES)) ?
			addr_sum - (ADDR_W+1)'(CARD_BYTES) : addr_sum;
		item_addr    = addr_sum_red[ADDR_W-1:0];
	end

	always_comb begin
		mode_d     = mode_q;
		base_d     = base_q;
		count_d    = count_q;
		from_mem_d = 1'b0;
		const_d    = BYTE_FILL;
		item_we    = 1'b0;
		item_re    = 1'b0;
		if (accept) begin
			case (kind)
				KIND_BEGIN: begin
					if (command == CMD_READ || command == CMD_WRITE) begin
						mode_d  = (command == CMD_READ) ? MODE_READ : MODE_WRITE;
						base_d  = red0[ADDR_W-1:0];
						count_d = '0;
					end else if (command == CMD_ID) begin
						mode_d  = MODE_ID;
						count_d = '0;
					end else begin
						mode_d = MODE_IDLE;
					end
				end
				KIND_READ: begin
					if (mode_q == MODE_READ) begin
						if (count_q < CNT_W'(FRAME_BYTES)) begin
							item_re    = 1'b1;
							from_mem_d = 1'b1;
							count_d    = count_q + CNT_W'(1);
						end else begin
							mode_d = MODE_IDLE;
						end
					end else if (mode_q == MODE_ID) begin
						if (count_q < CNT_W'(ID_LEN)) begin
							const_d = id_byte(count_q[2:0]);
							count_d = count_q + CNT_W'(1);
						end else begin
							mode_d = MODE_IDLE;
						end
					end
				end
				KIND_WRITE: begin
					if (mode_q == MODE_WRITE && count_q < CNT_W'(FRAME_BYTES)) begin
						item_we = 1'b1;
						count_d = count_q + CNT_W'(1);
						if (count_q == CNT_W'(FRAME_BYTES - 1)) begin
							mode_d = MODE_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			base_q  <= '0;
			count_q <= '0;
		end else begin
			mode_q  <= mode_d;
			base_q  <= base_d;
			count_q <= count_d;
		end
	end

	// formatting pass over the whole card after reset
	always_comb begin
		if (clr_addr_q == ADDR_W'(0)) begin
			clr_data = FMT_MAGIC0;
		end else if (clr_addr_q == ADDR_W'(1)) begin
			clr_data = FMT_MAGIC1;
		end else if (clr_addr_q == ADDR_W'(FRAME_BYTES - 1)) begin
			clr_data = FMT_CHECK;
		end else if (clr_addr_q == ADDR_W'(FRAME_BYTES)) begin
			clr_data = FMT_DIR_TAG;
		end else begin
			clr_data = BYTE_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(CARD_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_addr_q : item_addr;
	assign ram_wdata = clearing_q ? clr_data : write_data;

	mcft_ram #(
		.WIDTH (8),
		.DEPTH (CARD_BYTES)
	) u_card_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (item_re),
		.rd_addr (item_addr),
		.rd_data (ram_rdata)
	);

	// ram read stage; ram data holds since no new read issues while held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= from_mem_d;
			const_s1    <= const_d;
			idle_s1     <= (mode_d == MODE_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data <= from_mem_s1 ? ram_rdata : const_s1;
			idle      <= idle_s1;
		end
	end

	a_no_request_while_formatting: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !out_valid)
		else $error("request in flight during formatting pass");

	a_write_only_in_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		item_we |-> mode_q == MODE_WRITE && count_q < CNT_W'(FRAME_BYTES))
		else $error("card write outside a frame write");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FRAME_BYTES))
		else $error("byte count past frame size");

	a_id_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ID |-> count_q <= CNT_W'(ID_LEN))
		else $error("id reply index past end");

	// ram data only matters when the held request read the card
	a_read_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(from_mem_s1) &&
			(!from_mem_s1 || $stable(ram_rdata)))
		else $error("held read stage changed");

endmodule

`default_nettype wire
